[rtl/core/bse_pkg.sv]
// Package for the battery state-of-health estimator: register addresses,
// sequencer states and fixed constants. No dependencies.
`default_nettype none
package bse_pkg;
    localparam int unsigned REG_CAP   = 0;
    localparam int unsigned REG_TSTEP = 1;
    localparam int unsigned REG_DTHR  = 2;
    localparam int unsigned REG_CTHR  = 3;
    localparam int unsigned REG_MINF  = 4;
    localparam int unsigned REG_A1    = 5;
    localparam int unsigned REG_B0    = 6;
    localparam int unsigned REG_B1    = 7;

    localparam logic [16:0] HEALTH_ONE = 17'd65536;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WIN,
        ST_FLAG,
        ST_COUL,
        ST_ACC,
        ST_CHK,
        ST_DIV,
        ST_F0,
        ST_F1,
        ST_F2,
        ST_FSAT,
        ST_OUT
    } state_t;
endpackage
`default_nettype wire

[rtl/core/battery_soh_estimator.sv]
// Battery state-of-health estimator top level: window, hysteresis, coulomb
// counter, serial divider and IIR filter under one sequencer. Uses bse_pkg.
//
// An item goes from the estimate check straight to the output step when the
// charge/discharge state holds or the toggle gives no estimate; an estimate
// is taken without division when aberrant or raw is exactly 1.0, and
// otherwise the raw value goes through the divider. The steps are: window
// update, hysteresis compare, coulomb product, saturating accumulate,
// estimate check, a 16-step restoring divider and three filter taps; the
// coulomb product and the filter taps go through one shared 35x32
// multiplier. The window memory is cleared after reset by a pass over its
// WINDOW_LEN entries during which no item is accepted; configuration writes
// are taken throughout. A finished result sits in the output register while
// the block goes on to accept the next item; the following result waits in
// the output step until that register is free.
`default_nettype none
module battery_soh_estimator #(
    parameter int WINDOW_LEN    = 60,
    parameter int CURRENT_WIDTH = 24
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [5:0]               paddr,
    input  wire logic [63:0]              pwdata,
    output logic      [63:0]              prdata,
    output logic                          pready,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [CURRENT_WIDTH-1:0] s_current_ma,
    input  wire logic [16:0]              s_charge_level,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic      [16:0]              m_health,
    output logic                          m_discharging,
    output logic                          m_state_changed,
    output logic                          m_estimate_done,
    output logic                          m_aberrant
);
    import bse_pkg::*;

    localparam int PW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int SW = CURRENT_WIDTH + PW + 1;
    localparam logic [PW-1:0] PLAST = PW'(WINDOW_LEN - 1);

    // configuration
    logic [39:0]        cap_reg;
    logic [7:0]         tstep_reg;
    logic signed [23:0] dthr_reg, cthr_reg;
    logic [16:0]        minf_reg;
    logic signed [31:0] a1_reg, b0_reg, b1_reg;
    logic               wr_en;
    logic [2:0]         widx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign widx   = paddr[5:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg   <= 40'd4347258;
            tstep_reg <= 8'd1;
            dthr_reg  <= 24'sd100;
            cthr_reg  <= -24'sd1000;
            minf_reg  <= 17'd6554;
            a1_reg    <= -32'sd1040528215;
            b0_reg    <= 32'sd16606806;
            b1_reg    <= 32'sd16606806;
        end else if (wr_en && paddr[2:0] == 3'd0) begin
            case (32'(widx))
                REG_CAP:   cap_reg   <= pwdata[39:0];
                REG_TSTEP: tstep_reg <= pwdata[7:0];
                REG_DTHR:  dthr_reg  <= pwdata[23:0];
                REG_CTHR:  cthr_reg  <= pwdata[23:0];
                REG_MINF:  minf_reg  <= pwdata[16:0];
                REG_A1:    a1_reg    <= pwdata[31:0];
                REG_B0:    b0_reg    <= pwdata[31:0];
                REG_B1:    b1_reg    <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (32'(widx))
            REG_CAP:   prdata = {24'd0, cap_reg};
            REG_TSTEP: prdata = {56'd0, tstep_reg};
            REG_DTHR:  prdata = {{40{dthr_reg[23]}}, dthr_reg};
            REG_CTHR:  prdata = {{40{cthr_reg[23]}}, cthr_reg};
            REG_MINF:  prdata = {47'd0, minf_reg};
            REG_A1:    prdata = {{32{a1_reg[31]}}, a1_reg};
            REG_B0:    prdata = {{32{b0_reg[31]}}, b0_reg};
            REG_B1:    prdata = {{32{b1_reg[31]}}, b1_reg};
            default:   prdata = 64'd0;
        endcase
    end

    // window memory
    logic signed [CURRENT_WIDTH-1:0] win_mem [WINDOW_LEN];
    logic signed [CURRENT_WIDTH-1:0] win_rd_reg;
    logic [PW-1:0] wptr_reg, clr_ptr_reg;
    logic          clr_busy_reg;
    logic          mem_we;
    logic [PW-1:0] mem_wa;
    logic signed [CURRENT_WIDTH-1:0] mem_wd;

    state_t state_reg, state_next;

    logic signed [CURRENT_WIDTH-1:0] cur_reg;
    logic [16:0]         lvl_reg;
    logic signed [SW-1:0] wsum_reg;
    logic                flag_reg, changed_reg, done_reg, aberr_reg;
    logic signed [47:0]  integ_reg;
    logic [16:0]         latched_reg, fhealth_reg, praw_reg, raw_reg;
    logic [63:0]         num_reg, den_reg;
    logic [16:0]         q_reg;
    logic [4:0]          cnt_reg;
    logic signed [66:0]  acc_reg;
    logic signed [66:0]  prod_reg;
    logic                out_fire;

    always_ff @(posedge aclk) begin
        if (mem_we) win_mem[mem_wa] <= mem_wd;
        win_rd_reg <= win_mem[wptr_reg];
    end

    always_comb begin
        mem_we = clr_busy_reg || (state_reg == ST_WIN);
        mem_wa = clr_busy_reg ? clr_ptr_reg : wptr_reg;
        mem_wd = clr_busy_reg ? '0 : cur_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_ptr_reg  <= '0;
        end else if (clr_busy_reg) begin
            clr_ptr_reg  <= clr_ptr_reg + PW'(1);
            if (clr_ptr_reg == PLAST) clr_busy_reg <= 1'b0;
        end
    end

    // shared multiplier: 35 x 32 signed
    logic signed [34:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [66:0] mul_p;
    assign mul_p = mul_a * mul_b;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_COUL: begin
                mul_a = 35'(cur_reg);
                mul_b = {24'd0, tstep_reg};
            end
            ST_F0: begin
                mul_a = {18'd0, fhealth_reg};
                mul_b = a1_reg;
            end
            ST_F1: begin
                mul_a = {18'd0, raw_reg};
                mul_b = b0_reg;
            end
            ST_F2: begin
                mul_a = {18'd0, praw_reg};
                mul_b = b1_reg;
            end
            default: ;
        endcase
    end

    // threshold products and magnitudes
    logic signed [SW+8:0] dlim, clim;
    logic flag_new;
    logic signed [48:0] isum;
    logic [47:0] imag;
    logic signed [17:0] diff;
    logic [16:0] dmag;
    logic [63:0] den_full, num_full;
    logic [63:0] mf_cap;
    logic sign_ok;
    logic [64:0] rshift;

    assign dlim = (SW+9)'(dthr_reg) * (SW+9)'(WINDOW_LEN);
    assign clim = (SW+9)'(cthr_reg) * (SW+9)'(WINDOW_LEN);
    always_comb begin
        flag_new = flag_reg;
        if (!flag_reg && (SW+9)'(wsum_reg) > dlim) flag_new = 1'b1;
        else if (flag_reg && (SW+9)'(wsum_reg) < clim) flag_new = 1'b0;
    end

    assign isum = 49'(integ_reg) + 49'(prod_reg);
    assign imag = integ_reg[47] ? 48'(-integ_reg) : 48'(integ_reg);
    assign diff = {1'b0, latched_reg} - {1'b0, lvl_reg};
    assign dmag = diff[17] ? 17'(-diff) : diff[16:0];
    assign den_full = 64'(dmag) * 64'(cap_reg);
    assign num_full = {imag, 16'd0};
    assign mf_cap = 64'(minf_reg) * 64'(cap_reg);
    assign sign_ok = (integ_reg == '0) || (integ_reg[47] == diff[17]);
    assign rshift = {num_reg, 1'b0};

    // result leaves the output step once the output register is free
    assign out_fire = (state_reg == ST_OUT) && (!m_valid || m_ready);

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_valid && s_ready) state_next = ST_WIN;
            ST_WIN:  state_next = ST_FLAG;
            ST_FLAG: state_next = ST_COUL;
            ST_COUL: state_next = ST_ACC;
            ST_ACC:  state_next = ST_CHK;
            ST_CHK: begin
                if (!changed_reg) state_next = ST_OUT;
                else if (num_full > mf_cap) begin
                    if (den_full == 0 || !sign_ok || num_full > den_full)
                        state_next = ST_F0;
                    else if (num_full == den_full) state_next = ST_F0;
                    else state_next = ST_DIV;
                end else state_next = ST_OUT;
            end
            ST_DIV:  if (cnt_reg == 5'd15) state_next = ST_F0;
            ST_F0:   state_next = ST_F1;
            ST_F1:   state_next = ST_F2;
            ST_F2:   state_next = ST_FSAT;
            ST_FSAT: state_next = ST_OUT;
            ST_OUT:  if (out_fire) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE) && !clr_busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg    <= '0;
            wsum_reg    <= '0;
            flag_reg    <= 1'b0;
            integ_reg   <= '0;
            latched_reg <= '0;
            fhealth_reg <= HEALTH_ONE;
            praw_reg    <= HEALTH_ONE;
            m_valid     <= 1'b0;
        end else begin
            if (out_fire) m_valid <= 1'b1;
            else if (m_valid && m_ready) m_valid <= 1'b0;
            case (state_reg)
                ST_IDLE: if (s_valid && s_ready) begin
                    cur_reg   <= s_current_ma;
                    lvl_reg   <= s_charge_level;
                    done_reg  <= 1'b0;
                    aberr_reg <= 1'b0;
                end
                ST_WIN: begin
                    wsum_reg <= wsum_reg - SW'(win_rd_reg) + SW'(cur_reg);
                    wptr_reg <= (wptr_reg == PLAST) ? '0 : wptr_reg + PW'(1);
                end
                ST_FLAG: begin
                    changed_reg <= flag_new != flag_reg;
                    flag_reg    <= flag_new;
                    prod_reg    <= '0;
                end
                ST_COUL: prod_reg <= mul_p;
                ST_ACC: begin
                    if (isum > 49'sh0_7FFF_FFFF_FFFF)
                        integ_reg <= 48'sh7FFF_FFFF_FFFF;
                    else if (isum < -49'sh0_8000_0000_0000)
                        integ_reg <= 48'sh8000_0000_0000;
                    else integ_reg <= isum[47:0];
                end
                ST_CHK: begin
                    if (changed_reg && num_full > mf_cap &&
                        (den_full == 0 || !sign_ok || num_full > den_full))
                        aberr_reg <= 1'b1;
                end
                default: ;
            endcase
            if (out_fire) begin
                m_health        <= fhealth_reg;
                m_discharging   <= flag_reg;
                m_state_changed <= changed_reg;
                m_estimate_done <= done_reg;
                m_aberrant      <= aberr_reg;
                if (changed_reg) begin
                    latched_reg <= lvl_reg;
                    integ_reg   <= '0;
                end
            end
            if (state_reg == ST_FSAT) begin
                if (acc_reg < 0) fhealth_reg <= '0;
                else if (acc_reg[66:30] > 37'(HEALTH_ONE)) fhealth_reg <= HEALTH_ONE;
                else fhealth_reg <= acc_reg[46:30];
                praw_reg <= raw_reg;
                done_reg <= 1'b1;
            end
        end
    end

    // estimate datapath; ST_CHK sees the saturated integral from ST_ACC
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_CHK: begin
                num_reg <= num_full;
                den_reg <= den_full;
                q_reg   <= '0;
                cnt_reg <= '0;
                if (den_full == 0 || !sign_ok || num_full > den_full)
                    raw_reg <= fhealth_reg;
                else if (num_full == den_full) raw_reg <= HEALTH_ONE;
            end
            ST_DIV: begin
                cnt_reg <= cnt_reg + 5'd1;
                if (rshift >= {1'b0, den_reg}) begin
                    num_reg <= 64'(rshift - {1'b0, den_reg});
                    q_reg   <= {q_reg[15:0], 1'b1};
                    if (cnt_reg == 5'd15) raw_reg <= {q_reg[15:0], 1'b1};
                end else begin
                    num_reg <= rshift[63:0];
                    q_reg   <= {q_reg[15:0], 1'b0};
                    if (cnt_reg == 5'd15) raw_reg <= {q_reg[15:0], 1'b0};
                end
            end
            ST_F0: acc_reg <= 67'sd536870912 - mul_p;
            ST_F1: acc_reg <= acc_reg + mul_p;
            ST_F2: acc_reg <= acc_reg + mul_p;
            default: ;
        endcase
    end

    property p_no_accept_clr;
        @(posedge aclk) disable iff (!aresetn) clr_busy_reg |-> !s_ready;
    endproperty
    a_no_accept_clr: assert property (p_no_accept_clr) else $error("accept during clear");

    property p_out_after;
        @(posedge aclk) disable iff (!aresetn) (state_reg == ST_OUT) |=> m_valid;
    endproperty
    a_out_after: assert property (p_out_after) else $error("result lost");

    property p_health_range;
        @(posedge aclk) disable iff (!aresetn) fhealth_reg <= HEALTH_ONE;
    endproperty
    a_health_range: assert property (p_health_range) else $error("health range");

    property p_aberr_done;
        @(posedge aclk) disable iff (!aresetn) (m_valid && m_aberrant) |-> m_estimate_done;
    endproperty
    a_aberr_done: assert property (p_aberr_done) else $error("aberrant without estimate");
endmodule
`default_nettype wire
